// ===== sv/pidc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register map and a clamp helper for the clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

    // Gain format: signed Q(16-FRAC).FRAC
    localparam int FRAC_BITS = 8;

    localparam int DATA_W = 16;               // measurement, setpoint, drive
    localparam int GAIN_W = 16;
    localparam int LIM_W  = 15;
    localparam int ERR_W  = DATA_W + 1;       // exact setpoint - measurement
    localparam int DIFF_W = ERR_W + 1;        // exact error change
    localparam int ISUM_W = DATA_W;           // clamped integral sum

    localparam int PPROD_W = GAIN_W + ERR_W;  // gain * error
    localparam int DPROD_W = GAIN_W + DIFF_W; // gain * error change
    localparam int PTERM_W = PPROD_W - FRAC_BITS;
    localparam int DTERM_W = DPROD_W - FRAC_BITS;
    localparam int SUM_W   = DTERM_W + 2;     // holds p + i + d exactly

    // APB register map
    localparam int APB_DW = 32;
    localparam int APB_AW = 5;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [IDX_W-1:0] REG_KP       = 3'd1;
    localparam logic [IDX_W-1:0] REG_KI       = 3'd2;
    localparam logic [IDX_W-1:0] REG_KD       = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT    = 3'd4;

    localparam logic [GAIN_W-1:0] KP_RESET    = 16'd256;
    localparam logic [LIM_W-1:0]  LIMIT_RESET = 15'd100;

    typedef struct packed {
        logic signed [DATA_W-1:0] setpoint;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic        [LIM_W-1:0]  limit;
    } t_cfg;

    typedef struct packed {
        logic                    hit;
        logic signed [SUM_W-1:0] val;
    } t_clamp;

    // Symmetric clamp to +/- lim
    function automatic t_clamp clamp_sym(input logic signed [SUM_W-1:0] v,
                                         input logic [LIM_W-1:0] lim);
        logic signed [SUM_W-1:0] pos;
        logic signed [SUM_W-1:0] neg;
        t_clamp                  res;
        pos = $signed({{(SUM_W - LIM_W){1'b0}}, lim});
        neg = -pos;
        if (v > pos) begin
            res.hit = 1'b1;
            res.val = pos;
        end else if (v < neg) begin
            res.hit = 1'b1;
            res.val = neg;
        end else begin
            res.hit = 1'b0;
            res.val = v;
        end
        return res;
    endfunction

endpackage

// ===== sv/pidc_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_regs
// APB register file: setpoint, three gains and the output limit.
// ----------------------------------------------------------------------------
module pidc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidc_pkg::APB_AW-1:0]   paddr,
    input  logic [pidc_pkg::APB_DW-1:0]   pwdata,
    output logic [pidc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output pidc_pkg::t_cfg                o_cfg
);

    pidc_pkg::t_cfg                r_cfg;
    logic [pidc_pkg::IDX_W-1:0]    idx;
    logic                          wr_en;

    assign idx    = paddr[pidc_pkg::APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint <= '0;
            r_cfg.kp       <= pidc_pkg::KP_RESET;
            r_cfg.ki       <= '0;
            r_cfg.kd       <= '0;
            r_cfg.limit    <= pidc_pkg::LIMIT_RESET;
        end else if (wr_en) begin
            case (idx)
                pidc_pkg::REG_SETPOINT: begin
                    r_cfg.setpoint <= pwdata[pidc_pkg::DATA_W-1:0];
                end
                pidc_pkg::REG_KP: begin
                    r_cfg.kp <= pwdata[pidc_pkg::GAIN_W-1:0];
                end
                pidc_pkg::REG_KI: begin
                    r_cfg.ki <= pwdata[pidc_pkg::GAIN_W-1:0];
                end
                pidc_pkg::REG_KD: begin
                    r_cfg.kd <= pwdata[pidc_pkg::GAIN_W-1:0];
                end
                pidc_pkg::REG_LIMIT: begin
                    r_cfg.limit <= pwdata[pidc_pkg::LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            pidc_pkg::REG_SETPOINT: begin
                prdata = pidc_pkg::APB_DW'(unsigned'(r_cfg.setpoint));
            end
            pidc_pkg::REG_KP: begin
                prdata = pidc_pkg::APB_DW'(unsigned'(r_cfg.kp));
            end
            pidc_pkg::REG_KI: begin
                prdata = pidc_pkg::APB_DW'(unsigned'(r_cfg.ki));
            end
            pidc_pkg::REG_KD: begin
                prdata = pidc_pkg::APB_DW'(unsigned'(r_cfg.kd));
            end
            pidc_pkg::REG_LIMIT: begin
                prdata = pidc_pkg::APB_DW'(r_cfg.limit);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

// ===== sv/pid_controller_clamped_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_unit
// PID controller with symmetric anti-windup clamp on integral and drive.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input beat passes stage 1, stage 2 and the stage 3 output register.
// Throughput: one beat per cycle while the output accepts; each stage moves on when the next is
//   empty or draining, so bubbles collapse under output backpressure.
// Integral update is an add/clamp loop closed through one register in the last stage.
// Reset (synchronous, active low): registers to defaults, previous error
//   and integral sum to zero, all stages empty.
// ----------------------------------------------------------------------------
module pid_controller_clamped_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [pidc_pkg::DATA_W-1:0]         i_s_tdata,  // [15:0] measurement
    // output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [pidc_pkg::DATA_W-1:0]         o_m_tdata,  // [15:0] drive
    output logic                                o_m_tuser,  // [0] saturated
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pidc_pkg::APB_AW-1:0]         paddr,
    input  logic [pidc_pkg::APB_DW-1:0]         pwdata,
    output logic [pidc_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    pidc_pkg::t_cfg cfg;

    pidc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ------------------------------------------------------------------
    // Stage flow control. Stage 3 is the output register.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;
    logic ld1, ld2, ld3;

    assign rdy3 = !r_v3 || i_m_tready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign ld1 = i_s_tvalid && rdy1;
    assign ld2 = r_v1 && rdy2;
    assign ld3 = r_v2 && rdy3;

    assign o_s_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_s_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: error and error change. Previous error advances per beat.
    // ------------------------------------------------------------------
    logic signed [pidc_pkg::DATA_W-1:0]  meas;
    logic signed [pidc_pkg::ERR_W-1:0]   n_err;
    logic signed [pidc_pkg::DIFF_W-1:0]  n_diff;
    logic signed [pidc_pkg::ERR_W-1:0]   r_prev_err;
    logic signed [pidc_pkg::ERR_W-1:0]   r_err_s1;
    logic signed [pidc_pkg::DIFF_W-1:0]  r_diff_s1;

    assign meas   = $signed(i_s_tdata);
    assign n_err  = pidc_pkg::ERR_W'(cfg.setpoint) - pidc_pkg::ERR_W'(meas);
    assign n_diff = pidc_pkg::DIFF_W'(n_err) - pidc_pkg::DIFF_W'(r_prev_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
        end else if (ld1) begin
            r_prev_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_err_s1  <= n_err;
            r_diff_s1 <= n_diff;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: gain products, floor-shifted out of Q format.
    // ------------------------------------------------------------------
    logic signed [pidc_pkg::PPROD_W-1:0] prod_p;
    logic signed [pidc_pkg::PPROD_W-1:0] prod_i;
    logic signed [pidc_pkg::DPROD_W-1:0] prod_d;
    logic signed [pidc_pkg::PTERM_W-1:0] r_p_s2;
    logic signed [pidc_pkg::PTERM_W-1:0] r_i_s2;
    logic signed [pidc_pkg::DTERM_W-1:0] r_d_s2;

    assign prod_p = pidc_pkg::PPROD_W'(cfg.kp) * pidc_pkg::PPROD_W'(r_err_s1);
    assign prod_i = pidc_pkg::PPROD_W'(cfg.ki) * pidc_pkg::PPROD_W'(r_err_s1);
    assign prod_d = pidc_pkg::DPROD_W'(cfg.kd) * pidc_pkg::DPROD_W'(r_diff_s1);

    // dropping the low bits of a two's complement value is a floor shift
    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_p_s2 <= prod_p[pidc_pkg::PPROD_W-1:pidc_pkg::FRAC_BITS];
            r_i_s2 <= prod_i[pidc_pkg::PPROD_W-1:pidc_pkg::FRAC_BITS];
            r_d_s2 <= prod_d[pidc_pkg::DPROD_W-1:pidc_pkg::FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: integral update with clamp, sum, drive clamp.
    // ------------------------------------------------------------------
    logic signed [pidc_pkg::ISUM_W-1:0] r_isum;
    logic signed [pidc_pkg::ISUM_W-1:0] n_isum;
    logic signed [pidc_pkg::SUM_W-1:0]  isum_raw;
    logic signed [pidc_pkg::SUM_W-1:0]  total;
    pidc_pkg::t_clamp                   isum_clamp;
    pidc_pkg::t_clamp                   drive_clamp;
    logic signed [pidc_pkg::DATA_W-1:0] r_drive;
    logic                               r_sat;

    assign isum_raw   = pidc_pkg::SUM_W'(r_isum) + pidc_pkg::SUM_W'(r_i_s2);
    assign isum_clamp = pidc_pkg::clamp_sym(isum_raw, cfg.limit);
    // clamped value fits the limit range, so the low bits carry it
    assign n_isum     = isum_clamp.val[pidc_pkg::ISUM_W-1:0];
    assign total      = pidc_pkg::SUM_W'(r_p_s2) + pidc_pkg::SUM_W'(n_isum)
                      + pidc_pkg::SUM_W'(r_d_s2);
    assign drive_clamp = pidc_pkg::clamp_sym(total, cfg.limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isum <= '0;
        end else if (ld3) begin
            r_isum <= n_isum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r_drive <= drive_clamp.val[pidc_pkg::DATA_W-1:0];
            r_sat   <= drive_clamp.hit;
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_drive;
    assign o_m_tuser  = r_sat;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic signed [pidc_pkg::DATA_W-1:0] lim_pos;
    logic signed [pidc_pkg::DATA_W-1:0] lim_neg;

    assign lim_pos = $signed({1'b0, cfg.limit});
    assign lim_neg = -lim_pos;

    // drive stays inside the limit window
    a_drive_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_drive <= lim_pos) && (r_drive >= lim_neg))
        else $error("drive outside limit window");

    // a saturated result sits exactly on the limit
    a_sat_on_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_sat) |-> (r_drive == lim_pos) || (r_drive == lim_neg))
        else $error("saturated flag without drive on limit");

    // an accepted beat always lands in stage 1
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_v1)
        else $error("accepted beat lost at stage 1");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pid_controller_clamped_unit. The bench sends
// measurement beats and writes the gains over APB. A scoreboard predicts
// each drive beat and checks it. The bench first sends directed corners,
// then a back-pressure phase, then random phases with new gains.
// ----------------------------------------------------------------------------
module tb;

    localparam int RAND_SAMPLES = 850;
    localparam int HOLD_CYCLES  = 80;   // long output stall in the back-pressure phase
    localparam int WATCHDOG_MAX = 2000; // cycles without any beat on either stream
    localparam int DRAIN_CYCLES = 4;    // pipeline is 3 deep

    // One expected output beat
    typedef struct packed {
        logic signed [pidc_pkg::DATA_W-1:0] drive;
        logic                               saturated;
    } t_drive_beat;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the gains and of the loop state. It
    // predicts the drive of every accepted sample, in order.
    // ------------------------------------------------------------------------
    class pid_scoreboard;
        logic signed [pidc_pkg::DATA_W-1:0] setpoint;
        logic signed [pidc_pkg::GAIN_W-1:0] kp, ki, kd;
        logic        [pidc_pkg::LIM_W-1:0]  limit;
        logic signed [pidc_pkg::ERR_W-1:0]  last_err;
        logic signed [pidc_pkg::ISUM_W-1:0] integ;
        t_drive_beat                        expected[$];
        int errors, n_in, n_out, n_sat;

        function new();
            setpoint = '0;
            kp       = pidc_pkg::KP_RESET;
            ki       = '0;
            kd       = '0;
            limit    = pidc_pkg::LIMIT_RESET;
            last_err = '0;
            integ    = '0;
            errors   = 0;
            n_in     = 0;
            n_out    = 0;
            n_sat    = 0;
        endfunction

        function void write_reg(logic [pidc_pkg::IDX_W-1:0] idx,
                                logic [pidc_pkg::APB_DW-1:0] value);
            case (idx)
                pidc_pkg::REG_SETPOINT: setpoint = value[pidc_pkg::DATA_W-1:0];
                pidc_pkg::REG_KP:       kp       = value[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_KI:       ki       = value[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_KD:       kd       = value[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_LIMIT:    limit    = value[pidc_pkg::LIM_W-1:0];
                default: ;    // unmapped index: ignored
            endcase
        endfunction

        // symmetric clamp, floor-rounded gain products use >>> on longint
        function longint clip(longint v, longint lim, output logic hit);
            hit = 1'b1;
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            hit = 1'b0;
            return v;
        endfunction

        function void note_sample(logic signed [pidc_pkg::DATA_W-1:0] meas);
            longint      err, p_term, d_term, integ_l, total, lim;
            logic        hit;
            t_drive_beat want;
            lim     = longint'(limit);
            err     = longint'(setpoint) - longint'(meas);
            p_term  = (longint'(kp) * err) >>> pidc_pkg::FRAC_BITS;
            integ_l = clip(longint'(integ)
                           + ((longint'(ki) * err) >>> pidc_pkg::FRAC_BITS), lim, hit);
            d_term  = (longint'(kd) * (err - longint'(last_err))) >>> pidc_pkg::FRAC_BITS;
            integ    = integ_l[pidc_pkg::ISUM_W-1:0];
            last_err = err[pidc_pkg::ERR_W-1:0];
            total = clip(p_term + integ_l + d_term, lim, hit);
            want.drive     = total[pidc_pkg::DATA_W-1:0];
            want.saturated = hit;
            expected.push_back(want);
            n_in++;
        endfunction

        function void check_drive(logic [pidc_pkg::DATA_W-1:0] drive, logic sat);
            t_drive_beat want;
            n_out++;
            if (expected.size() == 0) begin
                errors++;
                $error("drive beat with nothing expected: drive %0d", $signed(drive));
                return;
            end
            want = expected.pop_front();
            if (sat === 1'b1)
                n_sat++;
            if (drive !== want.drive) begin
                errors++;
                $error("drive: expected %0d, got %0d", want.drive, $signed(drive));
            end
            if (sat !== want.saturated) begin
                errors++;
                $error("saturated: expected %0b, got %0b", want.saturated, sat);
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its connections
    // ------------------------------------------------------------------------
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [pidc_pkg::DATA_W-1:0]   i_s_tdata;   // [15:0] measurement
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [pidc_pkg::DATA_W-1:0]   o_m_tdata;   // [15:0] drive
    logic                          o_m_tuser;   // [0] saturated
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [pidc_pkg::APB_AW-1:0]   paddr;
    logic [pidc_pkg::APB_DW-1:0]   pwdata;
    logic [pidc_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    pid_controller_clamped_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    pid_scoreboard sb;

    // Idle controls for the sample driver and the drive sink, and the watchdog's idle count
    int tx_gap_pct   = 20;
    int rx_stall_pct = 20;
    int rx_hold_req  = 0;   // sink picks this up as the length of its next hold
    int idle_cycles  = 0;

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 50;
        endcase
    endfunction

    // Register value: either an extreme, fully random, or within +/- band
    function automatic logic [15:0] pick_word(int band);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7FFF;
        if (r < 4)  return 16'($urandom);
        return 16'($urandom_range(0, 2 * band)) - 16'(band);
    endfunction

    // Limit: zero, max, tiny, or anywhere. Bit 15 is noise that the DUT must drop.
    function automatic logic [15:0] pick_limit();
        logic [15:0] lim;
        case ($urandom_range(0, 5))
            0:       lim = 16'd0;
            1:       lim = 16'h7FFF;
            2:       lim = 16'($urandom_range(1, 15));
            default: lim = 16'($urandom_range(0, 32767));
        endcase
        lim[15] = 1'($urandom_range(0, 1));
        return lim;
    endfunction

    // Mostly near the setpoint, sometimes anywhere or at the rails
    function automatic logic [15:0] pick_sample(logic [15:0] sp);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        if (r < 3)  return 16'($urandom);
        return sp + 16'($urandom_range(0, 600)) - 16'd300;
    endfunction

    // ------------------------------------------------------------------------
    // APB write: setup, then access. The register takes the value at the
    // access edge. Upper data bits carry noise.
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [pidc_pkg::IDX_W-1:0] idx,
                             input logic [15:0] value);
        logic [pidc_pkg::APB_DW-1:0] noise;
        logic [pidc_pkg::APB_DW-1:0] word;
        noise = $urandom;
        word  = {noise[31:16], value};
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, word);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] sp, input logic [15:0] kp,
                                  input logic [15:0] ki, input logic [15:0] kd,
                                  input logic [15:0] lim);
        apb_write(pidc_pkg::REG_SETPOINT, sp);
        apb_write(pidc_pkg::REG_KP, kp);
        apb_write(pidc_pkg::REG_KI, ki);
        apb_write(pidc_pkg::REG_KD, kd);
        apb_write(pidc_pkg::REG_LIMIT, lim);
    endtask

    // Drop valid and hold it low for the pause length given by the caller
    task automatic tx_pause(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // One sample beat. Valid stays high so that back-to-back beats stay
    // back to back. A random gap may follow.
    task automatic send_sample(input logic [15:0] meas);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= meas;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if ($urandom_range(0, 99) < tx_gap_pct)
            tx_pause(gap_len());
    endtask

    // Wait until every expected drive beat has arrived, then let the pipe settle
    task automatic drain();
        tx_pause(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Drive sink: random stalls, plus the long hold when the main flow asks
    // for one. The hold is counted here, cycle by cycle.
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                i_m_tready <= 1'b0;
                stall_left = gap_len() - 1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Monitors: sample beats at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            sb.note_sample(i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_drive(o_m_tdata, o_m_tuser);
    end

    // Watchdog: too long without a beat on either stream means a hang
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, sb.pending());
            $display("** pid_controller_clamped_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main flow
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0]                sp;
        logic [pidc_pkg::IDX_W-1:0] idx;
        int                         sent;
        int                         n;
        int                         phases;

        sb         = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        phases     = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed corners ---
        // reset gains (kp = 1.0, limit 100): rails and around zero
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        drain();

        // widest error span with max limit, extreme gains; writes to
        // unmapped indexes must not disturb anything
        apply_settings(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        for (int i = pidc_pkg::REG_LIMIT + 1; i < (1 << pidc_pkg::IDX_W); i++) begin
            idx = pidc_pkg::IDX_W'(i);
            apb_write(idx, 16'($urandom));
        end
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain();

        apply_settings(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        drain();

        // zero limit: drive and integral pinned at 0
        apb_write(pidc_pkg::REG_LIMIT, 16'd0);
        send_sample(16'd5);
        send_sample(16'hFFF9);
        send_sample(16'h0000);
        drain();

        // wind up the integral, then shrink the limit: the clamp takes
        // effect only with the next sample
        apply_settings(16'd1000, 16'h0000, 16'h0400, 16'h0000, 16'h7FFF);
        repeat (4) send_sample(16'h0000);
        drain();
        apb_write(pidc_pkg::REG_LIMIT, 16'd50);
        send_sample(16'h0000);
        drain();
        phases = 5;

        // --- back pressure: sink holds off, source keeps pushing ---
        sp = pick_word(3000);
        apply_settings(sp, pick_word(1024), pick_word(256), pick_word(512), pick_limit());
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        rx_hold_req  = HOLD_CYCLES;
        sent = 0;
        repeat (40) begin
            send_sample(pick_sample(sp));
            sent++;
        end
        drain();
        phases++;

        // --- random phases, new settings each time ---
        while (sent < RAND_SAMPLES) begin
            sp = pick_word(3000);
            apply_settings(sp, pick_word(1024), pick_word(256), pick_word(512),
                           pick_limit());
            tx_gap_pct   = pick_pct();
            rx_stall_pct = pick_pct();
            n = $urandom_range(20, 70);
            if (n > RAND_SAMPLES - sent)
                n = RAND_SAMPLES - sent;
            repeat (n) send_sample(pick_sample(sp));
            sent += n;
            drain();
            phases++;
        end

        $display("Run covered %0d samples (%0d drive beats clamped) across %0d gain settings,",
                 sb.n_in, sb.n_sat, phases);
        $display("with zero and full-scale limits, rail errors and a %0d-cycle sink stall.",
                 HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** pid_controller_clamped_unit: PASSED **");
        end else begin
            $display("** pid_controller_clamped_unit: FAILED **");
        end
        $finish;
    end

endmodule
